/* rtl/anti_replay_window_check_top_macros.svh */
// assertion macros for the anti-replay window checker
`ifndef ANTI_REPLAY_WINDOW_CHECK_TOP_MACROS_SVH
`define ANTI_REPLAY_WINDOW_CHECK_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ARWC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ARWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/arwc_pkg.sv */
`default_nettype none

package arwc_pkg;

    localparam int unsigned SEQ_W       = 32;
    localparam int unsigned WINDOW      = 1024;
    localparam int unsigned SLOT_W      = $clog2(WINDOW);
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic             accepted;
        logic             older;
        logic             newer;
        logic [SEQ_W-1:0] newest;
    } arwc_status_t;

endpackage

`default_nettype wire

/* rtl/arwc_window.sv */
`default_nettype none

module arwc_window
    import arwc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             proc,
    input  wire logic [SEQ_W-1:0] seq,
    output arwc_status_t          status
);

    logic [WINDOW-1:0] map_reg;
    logic [WINDOW-1:0] map_next;
    logic [SEQ_W-1:0]  newest_reg;
    logic [SEQ_W-1:0]  newest_next;

    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] start;
    logic [SLOT_W-1:0] offset;
    logic [SEQ_W-1:0]  diff;
    logic [SEQ_W-1:0]  jump;
    logic              newer;
    logic              in_win;
    logic              hit;
    logic              big;

    always_comb begin
        slot   = seq[SLOT_W-1:0];
        newer  = seq > newest_reg;
        diff   = newest_reg - seq;
        jump   = seq - newest_reg;
        in_win = !newer && (diff[SEQ_W-1:SLOT_W] == '0);
        hit    = in_win && map_reg[slot];
        big    = |jump[SEQ_W-1:SLOT_W];
        start  = newest_reg[SLOT_W-1:0] + SLOT_W'(1);
        offset = '0;

        map_next    = map_reg;
        newest_next = newest_reg;

        if (proc) begin
            if (newer) begin
                // clear slots of numbers leaving the window (circular range)
                for (int i = 0; i < WINDOW; i++) begin
                    offset = SLOT_W'(i) - start;
                    if (big || (offset < jump[SLOT_W-1:0])) begin
                        map_next[i] = 1'b0;
                    end
                end
                map_next[slot] = 1'b1;
                newest_next    = seq;
            end else if (in_win && !hit) begin
                map_next[slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg    <= '0;
            newest_reg <= '0;
        end else begin
            map_reg    <= map_next;
            newest_reg <= newest_next;
        end
    end

    assign status.accepted = !hit;
    assign status.older    = !newer && !in_win;
    assign status.newer    = newer;
    assign status.newest   = newest_reg;

endmodule

`default_nettype wire

/* rtl/anti_replay_window_check_top.sv */
// Anti-replay sliding-window checker.
// Slave channel (s_tvalid/s_tready/s_tdata) carries one 32-bit packet
// sequence number per beat. Master channel (m_tvalid/m_tready/m_tdata)
// returns one result beat per input beat, in order: bit 0 accepted,
// bit 1 older_than_window.
// Pipeline: input register, then the window check and bitmap update,
// then the result register. m_tvalid rises once a beat moves from the
// input register to the result register. One beat per clock while
// m_tready is high; the bitmap update (a range-mask clear over the flop
// bitmap) is combinational, so back-to-back beats see each other's effects.
// Reset (aresetn low, synchronous) clears the bitmap, the newest number
// and both pipeline valids; number 0 is then accepted once.
// When m_tready is low with a result held, the input register still
// takes one more beat; after that s_tready drops until the result is
// taken. Nothing is dropped or repeated.
`default_nettype none

`include "anti_replay_window_check_top_macros.svh"

module anti_replay_window_check_top
    import arwc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SEQ_W-1:0]       s_tdata,  // [31:0] sequence_number
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata   // [0] accepted, [1] older_than_window
);

    logic             in_valid_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic             out_valid_reg;
    logic             out_accepted_reg;
    logic             out_older_reg;
    logic             adv;
    arwc_status_t     status;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    arwc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (adv),
        .seq     (in_seq_reg),
        .status  (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_seq_reg <= s_tdata;
        end
        if (adv) begin
            out_accepted_reg <= status.accepted;
            out_older_reg    <= status.older;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_older_reg, out_accepted_reg};

    `ARWC_ASSERT_NOW(a_older_is_accepted, aclk, aresetn, out_valid_reg,
        out_accepted_reg || !out_older_reg, "older-than-window result marked as replay")
    `ARWC_ASSERT_NEXT(a_newest_follows, aclk, aresetn, adv && status.newer,
        status.newest == $past(in_seq_reg), "newest number not advanced")
    `ARWC_ASSERT_NOW(a_newer_accepted, aclk, aresetn, adv && status.newer,
        status.accepted && !status.older, "newer number rejected or flagged old")
    `ARWC_ASSERT_NOW(a_ready_when_out_free, aclk, aresetn, !out_valid_reg,
        s_tready, "input stalled with empty result register")

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import arwc_pkg::*;

    localparam int unsigned HALF_PERIOD      = 10;
    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned RANDOM_PER_PHASE = 400;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned HOLD_OFF_CYCLES  = 400;
    localparam int unsigned HEAD_ROWS        = 19;
    localparam int unsigned ACC_BIT          = 0;
    localparam int unsigned OLD_BIT          = 1;
    localparam logic [SEQ_W-1:0] TOP_GUARD   = 32'hFFF0_0000;
    localparam logic [SEQ_W-1:0] GUARD_STEP  = 32'h0010_0000;

    typedef struct packed {
        bit acc;
        bit old;
    } verdict_t;

    typedef struct packed {
        logic [SEQ_W-1:0] num;
        bit               typed;
        verdict_t         want;
    } stim_row_t;

    localparam bit       TYPED     = 1'b1;
    localparam bit       PREDICTED = 1'b0;
    localparam verdict_t FRESH     = '{1'b1, 1'b0};
    localparam verdict_t REPLAY    = '{1'b0, 1'b0};
    localparam verdict_t STALE     = '{1'b1, 1'b1};

    // head rows run right after reset, the tail rows after the random part
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{32'd0,          TYPED,     FRESH},
        '{32'd0,          TYPED,     REPLAY},
        '{32'd1,          PREDICTED, FRESH},
        '{32'd1,          TYPED,     REPLAY},
        '{32'd1023,       PREDICTED, FRESH},
        '{32'd1,          PREDICTED, FRESH},
        '{32'd0,          PREDICTED, FRESH},
        '{32'd1024,       PREDICTED, FRESH},
        '{32'd0,          TYPED,     STALE},
        '{32'd1,          PREDICTED, FRESH},
        '{32'd3000,       PREDICTED, FRESH},
        '{32'd1977,       PREDICTED, FRESH},
        '{32'd1977,       TYPED,     REPLAY},
        '{32'd1976,       TYPED,     STALE},
        '{32'd3500,       PREDICTED, FRESH},
        '{32'd2977,       PREDICTED, FRESH},
        '{32'h7FFF_FFFF,  PREDICTED, FRESH},
        '{32'h8000_0000,  PREDICTED, FRESH},
        '{32'h7FFF_FFFF,  TYPED,     REPLAY},
        '{32'hFFFF_FFFF,  TYPED,     FRESH},
        '{32'hFFFF_FFFF,  TYPED,     REPLAY},
        '{32'hFFFF_FC00,  PREDICTED, FRESH},
        '{32'hFFFF_FBFF,  TYPED,     STALE},
        '{32'd0,          TYPED,     STALE},
        '{32'hFFFF_FFFE,  PREDICTED, FRESH}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SEQ_W-1:0]       s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    bit   [WINDOW-1:0]      seen_slots = '0;
    logic [SEQ_W-1:0]       newest_num = '0;
    logic [SEQ_W-1:0]       gen_top    = '0;

    int unsigned src_idle_pct  = 37;
    int unsigned sink_idle_pct = 82;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;
    int unsigned mismatches    = 0;
    int unsigned results_checked = 0;
    int unsigned replays_seen    = 0;
    int unsigned stale_seen      = 0;
    int unsigned window_advances = 0;

    stim_row_t sent_rows[$];
    verdict_t  expected_verdicts[$];

    anti_replay_window_check_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    function automatic verdict_t judge_number(input logic [SEQ_W-1:0] num);
        verdict_t      v;
        logic [SEQ_W:0] jump;
        int unsigned   k;
        v = FRESH;
        if (num > newest_num) begin
            jump = {1'b0, num} - {1'b0, newest_num};
            if (jump >= WINDOW) begin
                seen_slots = '0;
            end else begin
                for (k = 1; k <= jump; k++)
                    seen_slots[(newest_num + k) % WINDOW] = 1'b0;
            end
            newest_num = num;
            seen_slots[num % WINDOW] = 1'b1;
            window_advances++;
        end else if (newest_num - num < WINDOW) begin
            if (seen_slots[num % WINDOW])
                v.acc = 1'b0;
            else
                seen_slots[num % WINDOW] = 1'b1;
        end else begin
            v.old = 1'b1;
        end
        return v;
    endfunction

    // mostly steps ahead and looks back into the window, some noise
    function automatic logic [SEQ_W-1:0] pick_sequence_number();
        int unsigned      roll;
        int unsigned      back;
        logic [SEQ_W-1:0] num;
        roll = $urandom_range(99);
        if (roll < 60 && gen_top < TOP_GUARD) begin
            if (roll < 45)
                num = gen_top + $urandom_range(4, 1);
            else
                num = gen_top + $urandom_range(WINDOW + 64, 5);
        end else if (roll < 95) begin
            if (roll < 80)
                back = $urandom_range(WINDOW - 1, 0);
            else if (roll < 88)
                back = WINDOW - $urandom_range(1, 0);
            else
                back = $urandom_range(4 * WINDOW, WINDOW);
            num = (back > gen_top) ? '0 : gen_top - back;
        end else begin
            num = $urandom;
            if (num >= TOP_GUARD)
                num = num - GUARD_STEP;
        end
        if (num > gen_top)
            gen_top = num;
        return num;
    endfunction

    task automatic offer_row(input stim_row_t row);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge aclk);
        end
        sent_rows = {sent_rows, row};
        s_tvalid <= 1'b1;
        s_tdata  <= row.num;
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t  want;
        stim_row_t row;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result beat with no number pending: m_tdata=%0h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    results_checked++;
                    if (m_tdata[ACC_BIT] !== want.acc) begin
                        $error("accepted: expected %0b, actual %0b", want.acc, m_tdata[ACC_BIT]);
                        mismatches++;
                    end
                    if (m_tdata[OLD_BIT] !== want.old) begin
                        $error("older_than_window: expected %0b, actual %0b",
                               want.old, m_tdata[OLD_BIT]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                row  = sent_rows.pop_front();
                want = judge_number(s_tdata);
                if (row.typed)
                    want = row.want;
                expected_verdicts = {expected_verdicts, want};
                if (!want.acc)
                    replays_seen++;
                if (want.old)
                    stale_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned i;
        int unsigned p;
        stim_row_t   row;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < HEAD_ROWS; i++) begin
            offer_row(DIRECTED_ROWS[i]);
            if (DIRECTED_ROWS[i].num > gen_top)
                gen_top = DIRECTED_ROWS[i].num;
        end

        for (p = 0; p < 3; p++) begin
            if (p == 1) begin
                src_idle_pct  = 82;
                sink_idle_pct = 37;
            end
            if (p == 2) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_left     = HOLD_OFF_CYCLES;
            end
            repeat (RANDOM_PER_PHASE) begin
                row.num   = pick_sequence_number();
                row.typed = PREDICTED;
                row.want  = FRESH;
                offer_row(row);
            end
        end

        // top of the number space and the unhandled wrap
        for (i = HEAD_ROWS; i < $size(DIRECTED_ROWS); i++)
            offer_row(DIRECTED_ROWS[i]);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d numbers checked: %0d replays, %0d older than the window, %0d advances",
                 results_checked, replays_seen, stale_seen, window_advances);
        $display("idle mixes: sender-heavy, receiver-heavy, none; one %0d-cycle output stall",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
